>>> rtl/mttr_pkg.sv
// Shared types, constants and channel-expansion tables for the Morton untiler.
package mttr_pkg;

   localparam int TEXEL_W = 32;
   localparam int COORD_W = 10;
   localparam int CHAN_W  = 8;
   localparam int FMT_W   = 3;
   localparam int TILES_W = 8;
   localparam int IDX_W   = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam int MAX_TILES_DEFAULT = 128;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_FORMAT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TILES_WIDE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TILES_HIGH   = 2'd2;

   // pixel format codes; 6 and 7 are unused and give all-zero channels
   localparam logic [FMT_W-1:0] FMT_ABGR8888 = 3'd0;
   localparam logic [FMT_W-1:0] FMT_BGR888   = 3'd1;
   localparam logic [FMT_W-1:0] FMT_RGBA5551 = 3'd2;
   localparam logic [FMT_W-1:0] FMT_RGB565   = 3'd3;
   localparam logic [FMT_W-1:0] FMT_RGBA4444 = 3'd4;
   localparam logic [FMT_W-1:0] FMT_LUM8     = 3'd5;

   localparam logic [IDX_W-1:0] IDX_LAST = 6'd63;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } rgba_type;

   typedef logic [CHAN_W-1:0] lut5_type [32];
   typedef logic [CHAN_W-1:0] lut6_type [64];

   // v * 255 / 31, truncated, built at elaboration
   function automatic lut5_type build_scale5();
      lut5_type t;
      for (int i = 0; i < 32; i++) begin
         t[i] = CHAN_W'((i * 255) / 31);
      end
      return t;
   endfunction

   // v * 255 / 63, truncated, built at elaboration
   function automatic lut6_type build_scale6();
      lut6_type t;
      for (int i = 0; i < 64; i++) begin
         t[i] = CHAN_W'((i * 255) / 63);
      end
      return t;
   endfunction

   localparam lut5_type SCALE5_LUT = build_scale5();
   localparam lut6_type SCALE6_LUT = build_scale6();

endpackage

>>> rtl/mttr_channels.sv
// Valid/ready channel interfaces for texel requests and pixel responses.
interface mttr_req_if import mttr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [TEXEL_W-1:0] texel;

   modport source (output valid, output texel, input ready);
   modport sink   (input valid, input texel, output ready);
endinterface

interface mttr_rsp_if import mttr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] pixel_x;
   logic [COORD_W-1:0] pixel_y;
   logic [CHAN_W-1:0]  red;
   logic [CHAN_W-1:0]  green;
   logic [CHAN_W-1:0]  blue;
   logic [CHAN_W-1:0]  alpha;
   logic               image_end;

   modport source (output valid, output pixel_x, output pixel_y, output red, output green,
                   output blue, output alpha, output image_end, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input red, input green,
                   input blue, input alpha, input image_end, output ready);
endinterface

>>> rtl/mttr_expand.sv
// Texel to 8-bit RGBA expansion for the six supported pixel formats.
module mttr_expand import mttr_pkg::*; (
   input  logic [FMT_W-1:0]   pixel_format,
   input  logic [TEXEL_W-1:0] texel,
   output rgba_type           rgba
);

   logic [15:0] v;

   assign v = texel[15:0];

   always_comb begin
      rgba = '0;
      case (pixel_format)
         FMT_ABGR8888: begin
            rgba.alpha = texel[7:0];
            rgba.blue  = texel[15:8];
            rgba.green = texel[23:16];
            rgba.red   = texel[31:24];
         end
         FMT_BGR888: begin
            rgba.blue  = texel[7:0];
            rgba.green = texel[15:8];
            rgba.red   = texel[23:16];
            rgba.alpha = '1;
         end
         FMT_RGBA5551: begin
            rgba.alpha = v[0] ? '1 : '0;
            rgba.blue  = SCALE5_LUT[v[5:1]];
            rgba.green = SCALE5_LUT[v[10:6]];
            rgba.red   = SCALE5_LUT[v[15:11]];
         end
         FMT_RGB565: begin
            rgba.blue  = SCALE5_LUT[v[4:0]];
            rgba.green = SCALE6_LUT[v[10:5]];
            rgba.red   = SCALE5_LUT[v[15:11]];
            rgba.alpha = '1;
         end
         FMT_RGBA4444: begin
            // times 17 is the nibble repeated
            rgba.alpha = {v[3:0], v[3:0]};
            rgba.blue  = {v[7:4], v[7:4]};
            rgba.green = {v[11:8], v[11:8]};
            rgba.red   = {v[15:12], v[15:12]};
         end
         FMT_LUM8: begin
            rgba.red   = texel[7:0];
            rgba.green = texel[7:0];
            rgba.blue  = texel[7:0];
            rgba.alpha = '1;
         end
         default: rgba = '0;
      endcase
   end

endmodule

>>> rtl/morton_tile_untile_to_rgba_core.sv
// Top level: Morton 8x8 tile untiler with RGBA channel expansion.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+----------------------------------------------
//   req_ch  | in  | valid / ready      | texel[31:0]
//   rsp_ch  | out | valid / ready      | pixel_x, pixel_y, red, green, blue, alpha,
//           |     |                    | image_end
//   csr     | in  | csr_wr_en (no ack) | csr_index[1:0], csr_wdata[7:0]
//
// One item per cycle sustained while rsp ready stays high. An accepted req is registered in
// stage 1, then in stage 2, and rsp valid is driven from the stage 2 valid.
// Stage 1 registers the texel with its coordinates (tile counters advance on accept);
// stage 2 registers the expanded pixel. The format lookup is the longest path.
// Synchronous active-high reset clears counters, valids and the csr registers
// (format 0, one tile by one tile). A stalled rsp holds its item while stage 1 still
// takes one more; req ready drops only when both stages are full.
module morton_tile_untile_to_rgba_core import mttr_pkg::*; #(
   parameter int MAX_TILES = MAX_TILES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   mttr_req_if.sink              req_ch,
   mttr_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // counters never exceed the largest tile count ever in effect
   localparam int CNT_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
   localparam int CMP_W = (CNT_W + 1 > TILES_W) ? CNT_W + 1 : TILES_W;

   // csr registers
   logic [FMT_W-1:0]   pixel_format_ff, pixel_format_in;
   logic [TILES_W-1:0] tiles_wide_ff, tiles_wide_in;
   logic [TILES_W-1:0] tiles_high_ff, tiles_high_in;

   // position state
   logic [IDX_W-1:0] index_ff, index_in;
   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] row_ff, row_in;

   // stage 1: texel plus coordinates
   logic               s1_valid_ff, s1_valid_in;
   logic [TEXEL_W-1:0] s1_texel_ff, s1_texel_in;
   logic [COORD_W-1:0] s1_x_ff, s1_x_in;
   logic [COORD_W-1:0] s1_y_ff, s1_y_in;
   logic               s1_end_ff, s1_end_in;

   // stage 2: result register
   logic               s2_valid_ff, s2_valid_in;
   logic [COORD_W-1:0] s2_x_ff, s2_x_in;
   logic [COORD_W-1:0] s2_y_ff, s2_y_in;
   rgba_type           s2_rgba_ff, s2_rgba_in;
   logic               s2_end_ff, s2_end_in;

   logic s2_ready, s1_ready, accept;
   logic [CMP_W-1:0] tw, th, col_plus, row_plus, max_tiles;
   logic [2:0] x_in_tile, r_in_tile;
   logic last_in_tile, col_wrap, row_wrap;
   rgba_type rgba;

   // handshakes
   assign s2_ready = !s2_valid_ff || rsp_ch.ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign accept   = req_ch.valid && s1_ready;
   assign req_ch.ready = s1_ready;

   // tile counts: zero reads as one, large counts saturate
   assign max_tiles = CMP_W'(MAX_TILES);
   always_comb begin
      tw = CMP_W'(tiles_wide_ff);
      if (tiles_wide_ff == '0) begin
         tw = CMP_W'(1);
      end else if (tw > max_tiles) begin
         tw = max_tiles;
      end
      th = CMP_W'(tiles_high_ff);
      if (tiles_high_ff == '0) begin
         th = CMP_W'(1);
      end else if (th > max_tiles) begin
         th = max_tiles;
      end
   end

   // Z-order inside the tile: index bits are x0,r0,x1,r1,x2,r2
   assign x_in_tile = {index_ff[4], index_ff[2], index_ff[0]};
   assign r_in_tile = {index_ff[5], index_ff[3], index_ff[1]};

   assign col_plus     = CMP_W'(col_ff) + CMP_W'(1);
   assign row_plus     = CMP_W'(row_ff) + CMP_W'(1);
   assign last_in_tile = (index_ff == IDX_LAST);
   assign col_wrap     = (col_plus >= tw);
   assign row_wrap     = (row_plus >= th);

   // csr writes
   always_comb begin
      pixel_format_in = pixel_format_ff;
      tiles_wide_in   = tiles_wide_ff;
      tiles_high_in   = tiles_high_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PIXEL_FORMAT: pixel_format_in = csr_wdata[FMT_W-1:0];
            CSR_TILES_WIDE:   tiles_wide_in   = csr_wdata[TILES_W-1:0];
            CSR_TILES_HIGH:   tiles_high_in   = csr_wdata[TILES_W-1:0];
            default: ;
         endcase
      end
   end

   // position counters and stage 1
   always_comb begin
      index_in    = index_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      s1_texel_in = s1_texel_ff;
      s1_x_in     = s1_x_ff;
      s1_y_in     = s1_y_ff;
      s1_end_in   = s1_end_ff;
      s1_valid_in = s1_valid_ff && !s2_ready;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_texel_in = req_ch.texel;
         s1_x_in     = COORD_W'({col_ff, x_in_tile});
         // flipped row, modulo 1024
         s1_y_in     = COORD_W'({th, 3'b000}) - COORD_W'(1)
                       - COORD_W'({row_ff, 3'b000}) - COORD_W'(r_in_tile);
         s1_end_in   = last_in_tile && col_wrap && row_wrap;
         if (last_in_tile) begin
            index_in = '0;
            if (col_wrap) begin
               col_in = '0;
               row_in = row_wrap ? '0 : CNT_W'(row_plus);
            end else begin
               col_in = CNT_W'(col_plus);
            end
         end else begin
            index_in = index_ff + IDX_W'(1);
         end
      end
   end

   mttr_expand u_expand (
      .pixel_format (pixel_format_ff),
      .texel        (s1_texel_ff),
      .rgba         (rgba)
   );

   // stage 2
   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_x_in     = s2_x_ff;
      s2_y_in     = s2_y_ff;
      s2_rgba_in  = s2_rgba_ff;
      s2_end_in   = s2_end_ff;
      if (s2_ready) begin
         s2_valid_in = s1_valid_ff;
         s2_x_in     = s1_x_ff;
         s2_y_in     = s1_y_ff;
         s2_rgba_in  = rgba;
         s2_end_in   = s1_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_texel_ff <= s1_texel_in;
      s1_x_ff     <= s1_x_in;
      s1_y_ff     <= s1_y_in;
      s1_end_ff   <= s1_end_in;
      s2_x_ff     <= s2_x_in;
      s2_y_ff     <= s2_y_in;
      s2_rgba_ff  <= s2_rgba_in;
      s2_end_ff   <= s2_end_in;
      if (reset) begin
         pixel_format_ff <= FMT_ABGR8888;
         tiles_wide_ff   <= TILES_W'(1);
         tiles_high_ff   <= TILES_W'(1);
         index_ff        <= '0;
         col_ff          <= '0;
         row_ff          <= '0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
      end else begin
         pixel_format_ff <= pixel_format_in;
         tiles_wide_ff   <= tiles_wide_in;
         tiles_high_ff   <= tiles_high_in;
         index_ff        <= index_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         s1_valid_ff     <= s1_valid_in;
         s2_valid_ff     <= s2_valid_in;
      end
   end

   assign rsp_ch.valid     = s2_valid_ff;
   assign rsp_ch.pixel_x   = s2_x_ff;
   assign rsp_ch.pixel_y   = s2_y_ff;
   assign rsp_ch.red       = s2_rgba_ff.red;
   assign rsp_ch.green     = s2_rgba_ff.green;
   assign rsp_ch.blue      = s2_rgba_ff.blue;
   assign rsp_ch.alpha     = s2_rgba_ff.alpha;
   assign rsp_ch.image_end = s2_end_ff;

endmodule

>>> rtl/mttr_checker.sv
// Port-level assertions for the untiler top level, bound in below.
module mttr_checker import mttr_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [COORD_W-1:0] rsp_pixel_x,
   input logic [COORD_W-1:0] rsp_pixel_y,
   input logic               rsp_image_end
);

   // nothing comes out the cycle after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // the last texel of an image is the bottom-right corner of a tile (y is flipped)
   a_end_corner: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_image_end) |-> (rsp_pixel_x[2:0] == 3'd7 && rsp_pixel_y[2:0] == 3'd0))
      else $error("image end away from tile corner");

   // with an empty result register the input side is never blocked
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && $past(!reset)) |-> req_ready)
      else $error("req stalled while rsp empty");

   // a stalled result stays valid and keeps its coordinates
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pixel_x)
                                     && $stable(rsp_pixel_y)))
      else $error("stalled rsp changed");

endmodule

bind morton_tile_untile_to_rgba_core mttr_checker u_mttr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_pixel_x   (rsp_ch.pixel_x),
   .rsp_pixel_y   (rsp_ch.pixel_y),
   .rsp_image_end (rsp_ch.image_end)
);

>>> verif/tb_morton_tile_untile_to_rgba_core.sv
// Self-checking testbench for the Morton 8x8 tile untiler with RGBA channel expansion.
`timescale 1ns / 1ps

module tb_morton_tile_untile_to_rgba_core import mttr_pkg::*; ();

   // Run shape
   localparam int TEXELS_RANDOM   = 1200;  // random texels after the directed table
   localparam int HOLD_PHASE      = 3;     // phase in which the pixel side holds off
   localparam int RSP_HOLD_CYCLES = 300;   // length of that hold-off
   localparam int DRAIN_CYCLES    = 10;    // two-stage pipe, plenty of margin
   localparam int TIMEOUT_NS      = 4_000_000;
   localparam int MAX_ERR_PRINTS  = 10;

   // Format codes the block does not define; they give all-zero channels
   localparam logic [FMT_W-1:0] FMT_UNUSED6 = 3'd6;
   localparam logic [FMT_W-1:0] FMT_UNUSED7 = 3'd7;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      logic [CHAN_W-1:0]  alpha;
      logic               image_end;
   } pixel_item_type;

   // One directed item: the format it runs under, the texel, and a hand-written
   // pixel where the answer is obvious (typed); other rows go to the predictor.
   typedef struct packed {
      logic [FMT_W-1:0]   fmt;
      logic [TEXEL_W-1:0] texel;
      logic               typed;
      pixel_item_type     want;
   } texel_row_type;

   localparam int N_DIRECTED = 21;

   // Starts right after reset: one tile by one tile, so the first texels land
   // on the top rows (y flipped) of the single tile.
   localparam texel_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{FMT_ABGR8888, 32'h0000_0000, 1'b1, '{10'd0, 10'd7, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0}},
      '{FMT_ABGR8888, 32'hFFFF_FFFF, 1'b1, '{10'd1, 10'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}},
      '{FMT_ABGR8888, 32'h1122_3344, 1'b1, '{10'd0, 10'd6, 8'h11, 8'h22, 8'h33, 8'h44, 1'b0}},
      '{FMT_ABGR8888, 32'h8040_2010, 1'b1, '{10'd1, 10'd6, 8'h80, 8'h40, 8'h20, 8'h10, 1'b0}},
      '{FMT_BGR888,   32'hFFFF_FFFF, 1'b0, '0},
      '{FMT_BGR888,   32'hFF00_0000, 1'b0, '0},   // top byte ignored
      '{FMT_BGR888,   32'h00AA_5533, 1'b0, '0},
      '{FMT_RGBA5551, 32'h0000_FFFF, 1'b0, '0},
      '{FMT_RGBA5551, 32'hFFFF_0000, 1'b0, '0},   // upper half ignored
      '{FMT_RGBA5551, 32'h0000_0001, 1'b0, '0},   // alpha bit alone
      '{FMT_RGBA5551, 32'h0000_F83E, 1'b0, '0},   // red and blue full, green zero
      '{FMT_RGB565,   32'h0000_FFFF, 1'b0, '0},
      '{FMT_RGB565,   32'h0000_07E0, 1'b0, '0},   // six-bit green alone
      '{FMT_RGB565,   32'hFFFF_0000, 1'b0, '0},
      '{FMT_RGBA4444, 32'h0000_FFFF, 1'b0, '0},
      '{FMT_RGBA4444, 32'h0000_1234, 1'b0, '0},
      '{FMT_LUM8,     32'h0000_00FF, 1'b0, '0},
      '{FMT_LUM8,     32'hFFFF_FF00, 1'b0, '0},
      '{FMT_UNUSED6,  32'hFFFF_FFFF, 1'b0, '0},
      '{FMT_UNUSED7,  32'hFFFF_FFFF, 1'b0, '0},
      '{FMT_ABGR8888, 32'hDEAD_BEEF, 1'b0, '0}
   };

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   mttr_req_if texel_ch();
   mttr_rsp_if pixel_ch();

   morton_tile_untile_to_rgba_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (texel_ch),
      .rsp_ch    (pixel_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state: position counters plus our own copy of the registers
   logic [IDX_W-1:0]   pos_in_tile;
   int                 col_tile;
   int                 row_tile;
   logic [FMT_W-1:0]   cfg_format;
   logic [TILES_W-1:0] cfg_wide;
   logic [TILES_W-1:0] cfg_high;

   pixel_item_type pending_pixels[$];   // expected pixels, oldest first

   int texels_sent    = 0;
   int pixels_checked = 0;
   int pixel_errors   = 0;
   int images_done    = 0;
   int csr_writes     = 0;
   bit idle_off          = 1'b0;   // phase with no gaps on either side
   bit rsp_hold_pending  = 1'b0;   // asks the pixel side for one long hold-off

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Zero means one tile; anything past the tile limit saturates.
   function automatic int tile_count(input logic [TILES_W-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > MAX_TILES_DEFAULT) return MAX_TILES_DEFAULT;
      return int'(v);
   endfunction

   function automatic logic [CHAN_W-1:0] widen5(input logic [4:0] v);
      return CHAN_W'((int'(v) * 255) / 31);
   endfunction

   function automatic logic [CHAN_W-1:0] widen6(input logic [5:0] v);
      return CHAN_W'((int'(v) * 255) / 63);
   endfunction

   function automatic logic [CHAN_W-1:0] widen4(input logic [3:0] v);
      return CHAN_W'(int'(v) * 17);
   endfunction

   // Pixel for one texel at the current position, then step the position.
   task automatic untile_texel(input logic [TEXEL_W-1:0] t, output pixel_item_type p);
      int         tw;
      int         th;
      logic [2:0] xin;
      logic [2:0] rin;
      logic [15:0] v;
      tw  = tile_count(cfg_wide);
      th  = tile_count(cfg_high);
      // Z-order: even index bits give the column, odd bits the row
      xin = {pos_in_tile[4], pos_in_tile[2], pos_in_tile[0]};
      rin = {pos_in_tile[5], pos_in_tile[3], pos_in_tile[1]};
      v   = t[15:0];
      p   = '0;
      // coordinates wrap at 10 bits, which matters after a shrink mid-image
      p.pixel_x = COORD_W'(col_tile * 8 + int'(xin));
      p.pixel_y = COORD_W'(th * 8 - 1 - row_tile * 8 - int'(rin));
      case (cfg_format)
         FMT_ABGR8888: begin
            p.alpha = t[7:0];
            p.blue  = t[15:8];
            p.green = t[23:16];
            p.red   = t[31:24];
         end
         FMT_BGR888: begin
            p.blue  = t[7:0];
            p.green = t[15:8];
            p.red   = t[23:16];
            p.alpha = 8'hFF;
         end
         FMT_RGBA5551: begin
            p.alpha = v[0] ? 8'hFF : 8'h00;
            p.blue  = widen5(v[5:1]);
            p.green = widen5(v[10:6]);
            p.red   = widen5(v[15:11]);
         end
         FMT_RGB565: begin
            p.blue  = widen5(v[4:0]);
            p.green = widen6(v[10:5]);
            p.red   = widen5(v[15:11]);
            p.alpha = 8'hFF;
         end
         FMT_RGBA4444: begin
            p.alpha = widen4(v[3:0]);
            p.blue  = widen4(v[7:4]);
            p.green = widen4(v[11:8]);
            p.red   = widen4(v[15:12]);
         end
         FMT_LUM8: begin
            p.red   = t[7:0];
            p.green = t[7:0];
            p.blue  = t[7:0];
            p.alpha = 8'hFF;
         end
         default: begin
            // unknown format: channels stay zero, position still moves
         end
      endcase
      p.image_end = (pos_in_tile == IDX_LAST) && (col_tile + 1 >= tw) && (row_tile + 1 >= th);

      // A counter left at or past a new, smaller count wraps at its next step.
      if (pos_in_tile == IDX_LAST) begin
         pos_in_tile = '0;
         col_tile++;
         if (col_tile >= tw) begin
            col_tile = 0;
            row_tile++;
            if (row_tile >= th) row_tile = 0;
         end
      end else begin
         pos_in_tile = pos_in_tile + IDX_W'(1);
      end
   endtask

   // Mostly back to back, some short gaps, a few long ones.
   function automatic int idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (idle_off || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Small images most of the time so that image ends come often; the
   // zero, limit and saturating counts now and then.
   function automatic logic [TILES_W-1:0] pick_tiles();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return TILES_W'($urandom_range(1, 2));
      if (roll < 70) return '0;
      if (roll < 80) return TILES_W'($urandom_range(3, 8));
      if (roll < 88) return TILES_W'(MAX_TILES_DEFAULT);
      if (roll < 94) return TILES_W'($urandom_range(MAX_TILES_DEFAULT + 1, 255));
      return '1;
   endfunction

   function automatic logic [TEXEL_W-1:0] pick_texel();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return $urandom();
   endfunction

   task automatic log_pixel_error(input string what, input pixel_item_type want,
                                  input pixel_item_type got);
      pixel_errors++;
      if (pixel_errors <= MAX_ERR_PRINTS)
         $display({"%s: expected x=%0d y=%0d rgba=%h_%h_%h_%h end=%0d,",
                   " got x=%0d y=%0d rgba=%h_%h_%h_%h end=%0d"},
                  what, want.pixel_x, want.pixel_y, want.red, want.green, want.blue, want.alpha,
                  want.image_end, got.pixel_x, got.pixel_y, got.red, got.green, got.blue,
                  got.alpha, got.image_end);
   endtask

   // One register write; the caller drops the write enable after the last one.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_PIXEL_FORMAT: cfg_format = val[FMT_W-1:0];
         CSR_TILES_WIDE:   cfg_wide   = val;
         CSR_TILES_HIGH:   cfg_high   = val;
         default: ;
      endcase
      csr_writes++;
   endtask

   // which[0] format, which[1] width, which[2] height
   task automatic configure(input logic [FMT_W-1:0] fmt, input logic [TILES_W-1:0] wide,
                            input logic [TILES_W-1:0] high, input logic [2:0] which);
      if (which[0]) write_reg(CSR_PIXEL_FORMAT, CSR_DATA_W'(fmt));
      if (which[1]) write_reg(CSR_TILES_WIDE, wide);
      if (which[2]) write_reg(CSR_TILES_HIGH, high);
      csr_wr_en <= 1'b0;
   endtask

   // Stop offering texels and wait for every expected pixel. Each texel gives
   // exactly one pixel, so an empty queue means the pipe is empty too.
   task automatic settle();
      texel_ch.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // Offer one texel, predict its pixel on accept, then maybe go idle a while.
   task automatic send_texel(input logic [TEXEL_W-1:0] t, input logic typed,
                             input pixel_item_type want);
      pixel_item_type p;
      int             gap;
      texel_ch.valid <= 1'b1;
      texel_ch.texel <= t;
      do @(posedge clock); while (!texel_ch.ready);
      untile_texel(t, p);
      pending_pixels.push_back(typed ? want : p);
      texels_sent++;
      gap = idle_cycles();
      if (gap > 0) begin
         texel_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Pixel side: random ready pattern, plus one long hold-off on request so
   // that both stages fill and the texel side sees ready drop.
   initial begin : pixel_sink
      int gap;
      pixel_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_pending) begin
            rsp_hold_pending = 1'b0;
            pixel_ch.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         pixel_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         gap = idle_cycles();
         if (gap > 0) begin
            pixel_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // Check every accepted pixel against the oldest expectation.
   always @(posedge clock) begin : pixel_check
      pixel_item_type got;
      pixel_item_type want;
      if (!reset && pixel_ch.valid && pixel_ch.ready) begin
         got = '{pixel_ch.pixel_x, pixel_ch.pixel_y, pixel_ch.red, pixel_ch.green,
                 pixel_ch.blue, pixel_ch.alpha, pixel_ch.image_end};
         pixels_checked++;
         if (got.image_end) images_done++;
         if (pending_pixels.size() == 0) begin
            log_pixel_error("pixel with none expected", '0, got);
         end else begin
            want = pending_pixels.pop_front();
            if (got !== want) log_pixel_error("pixel mismatch", want, got);
         end
      end
   end

   initial begin : stimulus
      int         phase;
      int         n_items;
      logic [2:0] which;
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_index      <= CSR_PIXEL_FORMAT;
      csr_wdata      <= '0;
      texel_ch.valid <= 1'b0;
      texel_ch.texel <= '0;
      // predictor mirrors the reset state: format 0, one tile by one tile
      pos_in_tile = '0;
      col_tile    = 0;
      row_tile    = 0;
      cfg_format  = FMT_ABGR8888;
      cfg_wide    = 8'd1;
      cfg_high    = 8'd1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: channel extremes of every format, unknown formats.
      // A format change waits for the pipe to empty before the write.
      for (int k = 0; k < N_DIRECTED; k++) begin
         if (DIRECTED_ROWS[k].fmt != cfg_format) begin
            settle();
            configure(DIRECTED_ROWS[k].fmt, cfg_wide, cfg_high, 3'b001);
         end
         send_texel(DIRECTED_ROWS[k].texel, DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].want);
      end

      // Random phases. The first three pin the size extremes: zero and
      // saturated counts, a tall image cut short, then a shrink that leaves
      // the row counter past the new height so coordinates wrap.
      phase = 0;
      while (texels_sent < N_DIRECTED + TEXELS_RANDOM) begin
         settle();
         idle_off = ($urandom_range(0, 4) == 0);
         case (phase)
            0: configure(FMT_LUM8, 8'd0, 8'd255, 3'b111);
            1: configure(FMT_UNUSED7, 8'd255, 8'd0, 3'b111);
            2: configure(FMT_ABGR8888, 8'd1, 8'd1, 3'b111);
            default: begin
               which = 3'($urandom_range(1, 7));
               configure(3'($urandom_range(0, 7)), pick_tiles(), pick_tiles(), which);
            end
         endcase
         n_items = $urandom_range(20, 200);
         if (phase == HOLD_PHASE) begin
            n_items = 200;
            rsp_hold_pending = 1'b1;
         end
         repeat (n_items) send_texel(pick_texel(), 1'b0, '0);
         phase++;
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d texels, %0d pixels checked, %0d images completed, %0d register writes",
               texels_sent, pixels_checked, images_done, csr_writes);
      $display("over %0d random setting phases, %0d pixel errors", phase, pixel_errors);
      if (pixel_errors == 0) begin
         $display("tb_morton_tile_untile_to_rgba_core passed");
      end else begin
         $display("tb_morton_tile_untile_to_rgba_core failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("timeout with %0d pixels outstanding", pending_pixels.size());
      $display("tb_morton_tile_untile_to_rgba_core failed");
      $finish;
   end

endmodule

>>> sim.f
rtl/mttr_pkg.sv
rtl/mttr_channels.sv
rtl/mttr_expand.sv
rtl/morton_tile_untile_to_rgba_core.sv
rtl/mttr_checker.sv
verif/tb_morton_tile_untile_to_rgba_core.sv
